FILE: src/lmvf_pkg.sv
// ----------------------------------------------------------------------------
// lmvf_pkg
// shared types and constants for the four-neighbour valley finder
// ----------------------------------------------------------------------------
package lmvf_pkg;

  // result kind, carried on the master-side tuser
  typedef enum logic [0:0] {
    KIND_VALLEY  = 1'b0,
    KIND_SUMMARY = 1'b1
  } report_kind_t;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int FW_W         = 11;
  localparam int FH_W         = 13;
  localparam int ROW_W        = 12;
  localparam int TOTAL_W      = 22;
  localparam int SIZE_W       = 13;   // compare width for sizes and positions

  localparam logic [FW_W-1:0]    FRAME_WIDTH_RST  = 11'd4;
  localparam logic [FH_W-1:0]    FRAME_HEIGHT_RST = 13'd4;
  localparam logic [SIZE_W-1:0]  MIN_SIZE         = 13'd3;
  localparam logic [SIZE_W-1:0]  MAX_HEIGHT       = 13'd4096;
  localparam logic [TOTAL_W-1:0] COUNT_MAX        = 22'h3FFFFF;

endpackage

FILE: src/local_minimum_valley_finder.sv
// ----------------------------------------------------------------------------
// local_minimum_valley_finder
// streaming four-neighbour local minimum detector over a raster frame
// ----------------------------------------------------------------------------
// usage:
//   pixels enter on the slave stream (s_tvalid/s_tready/s_tdata), one signed
//   pixel per transfer in raster order. every interior pixel strictly below
//   its up, down, left and right neighbours is reported on the master stream
//   with m_tuser = valley, in raster order, one row late. the transfer that
//   closes the frame yields a summary (m_tuser = summary) carrying the
//   saturating valley total and a none-found flag.
// throughput: one pixel per clock unless the output stalls, set by the
//   combinational compare path and the one read port per line store; no
//   dead cycles at row or frame ends; reports are registered outputs.
// stall: a held result sits in the output register; a new pixel is still
//   taken in the cycle the result leaves, otherwise s_tready drops.
// config: apb port, frame_width at 0x0, frame_height at 0x4; write only while
//   no pixel is in flight. a new size applies from the next pixel, mid-frame
//   too. sizes are clamped to 3..MAX_WIDTH and 3..4096.
// reset: positions, window and valley count clear; line stores are not
//   cleared (rows 0 and 1 are never tested, so stale contents never matter).
// ----------------------------------------------------------------------------
module local_minimum_valley_finder #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // apb configuration port
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [lmvf_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [lmvf_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [lmvf_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                   pready,
  // pixel stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // s_tdata: pixel
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]        s_tdata,
  // report stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // m_tdata: valley_row, valley_col, valley_value, valley_total, none_found
  output logic [((lmvf_pkg::ROW_W + $clog2(MAX_WIDTH) + PIXEL_BITS
                  + lmvf_pkg::TOTAL_W + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  // m_tuser: report_kind
  output logic                                   m_tuser
);
  import lmvf_pkg::*;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int OUT_FIELDS = ROW_W + COL_W + PIXEL_BITS + TOTAL_W + 1;
  localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8;

  // configuration registers
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic            cfg_write;

  // frame position and count
  logic [COL_W-1:0]   col_pos;
  logic [COL_W-1:0]   col_pos_next;
  logic [ROW_W-1:0]   row_pos;
  logic [TOTAL_W-1:0] valley_count;

  // window on the previous row: left of center, center and right
  logic signed [PIXEL_BITS-1:0] win_left;
  logic signed [PIXEL_BITS-1:0] win_mid;
  logic signed [PIXEL_BITS-1:0] win_right;
  logic signed [PIXEL_BITS-1:0] col0_pixel;

  // line stores, read one item ahead
  logic signed [PIXEL_BITS-1:0] older_mem [MAX_WIDTH];
  logic signed [PIXEL_BITS-1:0] newer_mem [MAX_WIDTH];
  logic signed [PIXEL_BITS-1:0] older_rd;
  logic signed [PIXEL_BITS-1:0] newer_rd;
  logic [COL_W-1:0]             rd_col;
  logic [COL_W-1:0]             ahead_col;

  // datapath
  logic signed [PIXEL_BITS-1:0] pixel;
  logic [SIZE_W-1:0]            w_eff;
  logic [SIZE_W-1:0]            h_eff;
  logic [SIZE_W-1:0]            c_ext;
  logic [SIZE_W-1:0]            r_ext;
  logic                         s_accept;
  logic                         row_end;
  logic                         frame_end;
  logic                         interior;
  logic                         is_valley;

  // output register
  logic                         out_valid;
  report_kind_t                 out_kind;
  logic [ROW_W-1:0]             out_row;
  logic [COL_W-1:0]             out_col;
  logic signed [PIXEL_BITS-1:0] out_value;
  logic [TOTAL_W-1:0]           out_total;
  logic                         out_none;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      case (reg_index_t'(paddr[2]))
        REG_FRAME_WIDTH:  frame_width  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FH_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_FRAME_WIDTH:  prdata = CFG_DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = CFG_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // effective sizes, clamped
  // --------------------------------------------------------------------------
  always_comb begin
    w_eff = SIZE_W'(frame_width);
    if (w_eff < MIN_SIZE) begin
      w_eff = MIN_SIZE;
    end else if (w_eff > SIZE_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end
    h_eff = frame_height;
    if (h_eff < MIN_SIZE) begin
      h_eff = MIN_SIZE;
    end else if (h_eff > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end
  end

  // --------------------------------------------------------------------------
  // position decode and valley test
  // --------------------------------------------------------------------------
  assign s_tready = !out_valid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign pixel    = s_tdata[PIXEL_BITS-1:0];

  assign c_ext     = SIZE_W'(col_pos);
  assign r_ext     = SIZE_W'(row_pos);
  assign row_end   = c_ext >= (w_eff - SIZE_W'(1));
  assign frame_end = row_end && (r_ext >= (h_eff - SIZE_W'(1)));
  assign interior  = (r_ext >= SIZE_W'(2)) && (r_ext <= (h_eff - SIZE_W'(1)))
                  && (c_ext >= SIZE_W'(1)) && (c_ext <= (w_eff - SIZE_W'(2)));

  // at a row end the right neighbour wraps to column 0 of the row being stored
  assign win_right = row_end ? col0_pixel : newer_rd;

  assign is_valley = interior && (win_mid < older_rd) && (win_mid < pixel)
                  && (win_mid < win_left) && (win_mid < win_right);

  assign col_pos_next = row_end ? '0 : col_pos + COL_W'(1);

  // --------------------------------------------------------------------------
  // line stores: older holds row r-2, newer holds row r-1 ahead of the
  // current column. reads follow the position that the next pixel will see
  // --------------------------------------------------------------------------
  assign rd_col    = s_accept ? col_pos_next : col_pos;
  assign ahead_col = (rd_col == COL_W'(MAX_WIDTH - 1)) ? '0 : rd_col + COL_W'(1);

  always_ff @(posedge clk) begin
    if (s_accept) begin
      older_mem[col_pos] <= win_mid;
      newer_mem[col_pos] <= pixel;
    end
    older_rd <= older_mem[rd_col];
    newer_rd <= newer_mem[ahead_col];
  end

  always_ff @(posedge clk) begin
    if (s_accept && (col_pos == '0)) begin
      col0_pixel <= pixel;
    end
  end

  // --------------------------------------------------------------------------
  // position, window and count
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos      <= '0;
      row_pos      <= '0;
      valley_count <= '0;
      win_left     <= '0;
      win_mid      <= '0;
    end else if (s_accept) begin
      win_left <= win_mid;
      win_mid  <= win_right;
      col_pos  <= col_pos_next;
      if (frame_end) begin
        row_pos      <= '0;
        valley_count <= '0;
      end else begin
        if (row_end) begin
          row_pos <= row_pos + ROW_W'(1);
        end
        if (is_valley && (valley_count != COUNT_MAX)) begin
          valley_count <= valley_count + TOTAL_W'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_accept) begin
      out_valid <= is_valley || frame_end;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      if (frame_end) begin
        out_kind  <= KIND_SUMMARY;
        out_row   <= '0;
        out_col   <= '0;
        out_value <= '0;
        out_total <= valley_count;
        out_none  <= (valley_count == '0);
      end else begin
        out_kind  <= KIND_VALLEY;
        out_row   <= row_pos - ROW_W'(1);
        out_col   <= col_pos;
        out_value <= win_mid;
        out_total <= '0;
        out_none  <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = OUT_W'({out_none, out_total, out_value, out_col, out_row});

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_summary_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_SUMMARY)) |-> (out_none == (out_total == '0)))
    else $error("summary none-found flag disagrees with total");

  a_valley_interior: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind == KIND_VALLEY)) |-> ((out_row != '0) && (out_col != '0)))
    else $error("valley reported on the frame border");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (s_accept && frame_end) |=> ((col_pos == '0) && (row_pos == '0)
                                 && (valley_count == '0)))
    else $error("position or count not cleared after frame end");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !frame_end) |=> (valley_count >= $past(valley_count)))
    else $error("valley count went backwards inside a frame");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |-> !s_tready)
    else $error("input taken while a result is stalled");

endmodule

FILE: test/tb_local_minimum_valley_finder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_local_minimum_valley_finder
// self-checking bench for the streaming four-neighbour valley finder
// ----------------------------------------------------------------------------
// a queue of pixels feeds a clocked stream driver; a clocked monitor takes the
// reports and compares each field with the oldest expected report. expected
// reports come from a cycle-free model of the line stores, the 3-pixel window
// and the frame counters, run when a pixel is queued and released to the
// checker when that pixel's transfer completes. frame sizes go through the
// apb port between frames (twice mid-frame as well) and are read back. stimulus:
// hand-made minimum and mid-frame resize frames, then random frames with
// random, narrow-range and extreme fills, clamped sizes included, under three
// stall patterns
// ----------------------------------------------------------------------------
module tb_local_minimum_valley_finder;
  import lmvf_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int MAX_H       = 4096;
  localparam int PIX_BITS    = 16;
  localparam int COL_BITS    = 10;
  localparam int RANDOM_PX   = 1250;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 40;

  // m_tdata layout, lowest bit up: row, col, value, total, none_found
  localparam int COL_LSB  = ROW_W;
  localparam int VAL_LSB  = COL_LSB + COL_BITS;
  localparam int TOT_LSB  = VAL_LSB + PIX_BITS;
  localparam int NONE_BIT = TOT_LSB + TOTAL_W;

  // hand-made frames: a 3x3 frame with its one valley at the extremes, then a
  // 5-wide frame that is narrowed to 4 in row 2 and cut to 3 rows in row 4,
  // holding two ties and one valley at row 2 column 1
  localparam int DIRECTED_PX [0:30] = '{
    32767, 32767, 32767,  0, -32768, -1,  5, -32767, 5,
    9, 9, 9, 9, 9,  9, 2, 2, 9, 9,  9, 0, 5,
    9,
    9, 3, 9, 9,
    9, 9, 9, 9
  };

  typedef enum {PHASE_RX_HEAVY, PHASE_TX_HEAVY, PHASE_NO_IDLE} stall_phase_t;
  typedef enum {FILL_FULL, FILL_NARROW, FILL_EXTREME} fill_t;

  typedef struct {
    report_kind_t              kind;
    logic [ROW_W-1:0]          row;
    logic [COL_BITS-1:0]       col;
    logic signed [PIX_BITS-1:0] value;
    logic [TOTAL_W-1:0]        total;
    logic                      none_found;
  } valley_report_t;

  typedef struct {
    logic signed [PIX_BITS-1:0] pixel;
    bit                         has_report;
    valley_report_t             report;
  } pixel_item_t;

  // dut ports, all inputs known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [PIX_BITS-1:0]   s_tdata = '0;   // pixel
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [63:0]           m_tdata;        // row, col, value, total, none_found
  logic                  m_tuser;        // report kind

  // pixel queue and reports waiting for the monitor
  pixel_item_t    pixel_queue [$];
  pixel_item_t    in_flight;
  valley_report_t expected_reports [$];

  // model state: line stores, window, positions and the size registers
  logic signed [PIX_BITS-1:0] line_older [MAX_W] = '{default: '0};
  logic signed [PIX_BITS-1:0] line_newer [MAX_W] = '{default: '0};
  logic signed [PIX_BITS-1:0] win [3] = '{default: '0};
  int                         col_pos = 0;
  int                         row_pos = 0;
  logic [TOTAL_W-1:0]         valley_cnt = '0;
  logic [FW_W-1:0]            width_reg = FRAME_WIDTH_RST;
  logic [FH_W-1:0]            height_reg = FRAME_HEIGHT_RST;

  stall_phase_t stall_phase = PHASE_RX_HEAVY;
  int pushed_px = 0;
  int accepted_px = 0;
  int valleys_seen = 0;
  int frames_seen = 0;
  int settings_used = 0;
  int err_count = 0;
  int unsigned cycle_count = 0;

  local_minimum_valley_finder u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop well beyond the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports still expected", cycle_count,
               expected_reports.size());
      $display("[local_minimum_valley_finder] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (err_count < PRINT_LIMIT)
      $display("%0t mismatch in %s: got %0d, expected %0d (report %0d)", $time, field, got,
               want, valleys_seen + frames_seen);
    err_count++;
  endtask

  function automatic bit idle_roll(input bit sender_side);
    int pct;
    case (stall_phase)
      PHASE_RX_HEAVY: pct = sender_side ? 9 : 61;
      PHASE_TX_HEAVY: pct = sender_side ? 61 : 9;
      default:        pct = 0;
    endcase
    return $urandom_range(99) < pct;
  endfunction

  // one pixel through the window; returns 1 when it yields a report
  function automatic bit predict_pixel(input logic signed [PIX_BITS-1:0] px,
                                       output valley_report_t rep);
    int w, h, c, r, ci, ri;
    bit row_end, found;
    logic signed [PIX_BITS-1:0] up, mid;
    w = width_reg;
    h = height_reg;
    if (w < 3) w = 3;
    if (w > MAX_W) w = MAX_W;
    if (h < 3) h = 3;
    if (h > MAX_H) h = MAX_H;
    c = col_pos;
    r = row_pos;
    row_end = (c >= w - 1);
    ci = c % MAX_W;
    ri = row_end ? 0 : (c + 1) % MAX_W;
    rep.kind = KIND_VALLEY;
    rep.row = '0;
    rep.col = '0;
    rep.value = '0;
    rep.total = '0;
    rep.none_found = 1'b0;
    found = 1'b0;

    // right neighbour of row r-1 enters the window, up comes from row r-2
    win[2] = line_newer[ri];
    up = line_older[ci];
    mid = win[1];
    // pixel (r-1, c) is tested against up, down (this pixel), left and right
    if (r >= 2 && r <= h - 1 && c >= 1 && c <= w - 2 &&
        mid < up && mid < px && mid < win[0] && mid < win[2]) begin
      if (valley_cnt < COUNT_MAX) valley_cnt++;
      rep.row = ROW_W'(r - 1);
      rep.col = COL_BITS'(c);
      rep.value = mid;
      found = 1'b1;
    end

    line_older[ci] = win[1];
    line_newer[ci] = px;
    win[0] = win[1];
    win[1] = win[2];

    if (row_end) begin
      col_pos = 0;
      // a row at or past the last one closes the frame with a summary
      if (r >= h - 1) begin
        rep.kind = KIND_SUMMARY;
        rep.row = '0;
        rep.col = '0;
        rep.value = '0;
        rep.total = valley_cnt;
        rep.none_found = (valley_cnt == '0);
        found = 1'b1;
        row_pos = 0;
        valley_cnt = '0;
      end else begin
        row_pos = (r + 1) % MAX_H;
      end
    end else begin
      col_pos = (c + 1) % MAX_W;
    end
    return found;
  endfunction

  function automatic logic signed [PIX_BITS-1:0] gen_pixel(input fill_t fill);
    case (fill)
      FILL_FULL:   return PIX_BITS'($urandom());
      FILL_NARROW: return PIX_BITS'(int'($urandom_range(8)) - 4);   // many ties
      default: begin
        case ($urandom_range(5))
          0:       return 16'sh8000;
          1:       return 16'sh8001;
          2:       return -16'sd1;
          3:       return 16'sd0;
          4:       return 16'sh7FFE;
          default: return 16'sh7FFF;
        endcase
      end
    endcase
  endfunction

  task automatic push_pixel(input logic signed [PIX_BITS-1:0] px);
    pixel_item_t item;
    item.pixel = px;
    item.has_report = predict_pixel(px, item.report);
    pixel_queue.push_back(item);
    pushed_px++;
  endtask

  task automatic push_span(input int first, input int last);
    for (int i = first; i <= last; i++) push_pixel(PIX_BITS'(DIRECTED_PX[i]));
  endtask

  // pixels up to and including the one that closes the current frame
  task automatic send_frame(input fill_t fill);
    do push_pixel(gen_pixel(fill)); while (col_pos != 0 || row_pos != 0);
  endtask

  // all pixels taken and all reports in, then the pipeline is left to drain
  task automatic settle();
    do @(negedge clk); while (accepted_px != pushed_px || expected_reports.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input bit is_write, input reg_index_t idx,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_sizes();
    logic [CFG_DATA_W-1:0] rd;
    apb_access(1'b0, REG_FRAME_WIDTH, '0, rd);
    if (rd != CFG_DATA_W'(width_reg)) report_mismatch("frame_width readback", rd, width_reg);
    apb_access(1'b0, REG_FRAME_HEIGHT, '0, rd);
    if (rd != CFG_DATA_W'(height_reg)) report_mismatch("frame_height readback", rd, height_reg);
  endtask

  // bits above each register are random and must be dropped
  task automatic set_frame(input int w, input int h);
    logic [CFG_DATA_W-1:0] rd;
    width_reg = FW_W'(w);
    height_reg = FH_W'(h);
    apb_access(1'b1, REG_FRAME_WIDTH, ($urandom() << FW_W) | CFG_DATA_W'(width_reg), rd);
    apb_access(1'b1, REG_FRAME_HEIGHT, ($urandom() << FH_W) | CFG_DATA_W'(height_reg), rd);
    check_sizes();
    settings_used++;
  endtask

  // stream driver: holds a pixel until its transfer, then releases its report
  always @(posedge clk) begin : pixel_driver
    bit busy;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      busy = s_tvalid && !s_tready;
      if (s_tvalid && s_tready) begin
        if (in_flight.has_report) expected_reports.push_back(in_flight.report);
        accepted_px++;
      end
      if (!busy) begin
        if (pixel_queue.size() != 0 && !idle_roll(1'b1)) begin
          in_flight = pixel_queue.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= in_flight.pixel;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // report monitor: every field against the oldest expected report
  always @(posedge clk) begin : report_monitor
    valley_report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          report_mismatch("report with none expected", m_tuser, -1);
        end else begin
          want = expected_reports.pop_front();
          if (m_tuser != want.kind) report_mismatch("report kind", m_tuser, want.kind);
          if (m_tdata[0 +: ROW_W] != want.row)
            report_mismatch("valley_row", m_tdata[0 +: ROW_W], want.row);
          if (m_tdata[COL_LSB +: COL_BITS] != want.col)
            report_mismatch("valley_col", m_tdata[COL_LSB +: COL_BITS], want.col);
          if ($signed(m_tdata[VAL_LSB +: PIX_BITS]) != want.value)
            report_mismatch("valley_value", $signed(m_tdata[VAL_LSB +: PIX_BITS]), want.value);
          if (m_tdata[TOT_LSB +: TOTAL_W] != want.total)
            report_mismatch("valley_total", m_tdata[TOT_LSB +: TOTAL_W], want.total);
          if (m_tdata[NONE_BIT] != want.none_found)
            report_mismatch("none_found", m_tdata[NONE_BIT], want.none_found);
          if (want.kind == KIND_SUMMARY) frames_seen++;
          else valleys_seen++;
        end
      end
      m_tready <= !idle_roll(1'b0);
    end
  end

  initial begin : stimulus
    int small_px, w, h, px_mark;
    small_px = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_sizes();   // reset values

    // smallest frame, one valley at the most negative value
    set_frame(3, 3);
    push_span(0, 8);
    settle();
    // resize inside a frame: narrowing ends row 2 at once, cutting the
    // height below the current row ends the frame with that row
    set_frame(5, 8);
    push_span(9, 21);
    settle();
    set_frame(4, 8);
    push_span(22, 26);
    settle();
    set_frame(4, 3);
    push_span(27, 30);
    settle();

    // random frames, some of them at clamped sizes
    while (small_px < RANDOM_PX) begin
      if (small_px >= 2 * RANDOM_PX / 3) stall_phase = PHASE_NO_IDLE;
      else if (small_px >= RANDOM_PX / 3) stall_phase = PHASE_TX_HEAVY;
      settle();
      w = $urandom_range(12, 3);
      h = $urandom_range(9, 3);
      case ($urandom_range(9))
        0:       w = $urandom_range(2);   // clamps up to 3
        1:       h = $urandom_range(2);
        default: ;
      endcase
      set_frame(w, h);
      repeat ($urandom_range(3, 1)) begin
        px_mark = pushed_px;
        send_frame(fill_t'($urandom_range(2)));
        small_px += pushed_px - px_mark;
      end
    end
    settle();
    repeat (4) @(posedge clk);

    $display("%0d pixels in %0d frames, %0d valley reports, %0d frame-size settings",
             accepted_px, frames_seen, valleys_seen, settings_used);
    $display("sizes from 3x3 to 12 wide and 9 high, clamped small values and mid-frame resize");
    if (err_count == 0) begin
      $display("[local_minimum_valley_finder] OK");
    end else begin
      $display("[local_minimum_valley_finder] ERROR");
    end
    $finish;
  end

endmodule
